/* design/bsoq_pkg.sv */
// shared types and constants for the box / sphere overlap query block
package bsoq_pkg;

  localparam int AXES         = 3;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_QUERY_SHAPE    = 3'd0,
    REG_QUERY_CENTER_X = 3'd1,
    REG_QUERY_CENTER_Y = 3'd2,
    REG_QUERY_CENTER_Z = 3'd3,
    REG_QUERY_SIZE_X   = 3'd4,
    REG_QUERY_SIZE_Y   = 3'd5,
    REG_QUERY_SIZE_Z   = 3'd6
  } cfg_reg_t;

  localparam logic SHAPE_BOX    = 1'b0;
  localparam logic SHAPE_SPHERE = 1'b1;

  typedef struct packed {
    logic q_sphere;
    logic e_sphere;
  } pair_mode_t;

endpackage

/* design/bsoq_if.sv */
// channel interfaces: collider entries, overlap results, configuration writes
interface bsoq_entry_if #(
  parameter int COORD_BITS = 32,
  parameter int ID_BITS    = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         entry_shape;
  logic signed [COORD_BITS-1:0] entry_center_x;
  logic signed [COORD_BITS-1:0] entry_center_y;
  logic signed [COORD_BITS-1:0] entry_center_z;
  logic        [COORD_BITS-2:0] entry_size_x;
  logic        [COORD_BITS-2:0] entry_size_y;
  logic        [COORD_BITS-2:0] entry_size_z;
  logic        [ID_BITS-1:0]    entry_id;
  logic                         last_entry;

  modport source (
    output valid, entry_shape, entry_center_x, entry_center_y, entry_center_z,
           entry_size_x, entry_size_y, entry_size_z, entry_id, last_entry,
    input  ready
  );
  modport sink (
    input  valid, entry_shape, entry_center_x, entry_center_y, entry_center_z,
           entry_size_x, entry_size_y, entry_size_z, entry_id, last_entry,
    output ready
  );
endinterface

interface bsoq_result_if #(
  parameter int ID_BITS = 16
) ();
  logic               valid;
  logic               ready;
  logic               overlaps;
  logic [ID_BITS-1:0] result_id;
  logic               last_result;

  modport source (output valid, overlaps, result_id, last_result, input ready);
  modport sink   (input valid, overlaps, result_id, last_result, output ready);
endinterface

interface bsoq_cfg_if import bsoq_pkg::*; #(
  parameter int COORD_BITS = 32
) ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COORD_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/bsoq_pipe.sv */
// six-stage overlap test pipeline: bounds, clamp distance, squares, sums, compare
module bsoq_pipe import bsoq_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int ID_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         query_shape,
  input  logic signed [COORD_BITS-1:0] query_center [AXES],
  input  logic        [COORD_BITS-2:0] query_size   [AXES],
  bsoq_entry_if.sink                   in_ch,
  bsoq_result_if.source                out_ch
);

  localparam int C          = COORD_BITS;
  localparam int NUM_STAGES = 6;
  localparam int SQ_BITS    = 2 * C;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] adv;
  logic [ID_BITS-1:0]    id_r   [NUM_STAGES];
  logic                  last_r [NUM_STAGES];
  pair_mode_t            mode_r [NUM_STAGES];
  pair_mode_t            mode_nxt;

  // a stage loads when it is empty or the stage after it moves on
  always_comb begin
    adv[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ch.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign mode_nxt.q_sphere = (query_shape == SHAPE_SPHERE);
  assign mode_nxt.e_sphere = (in_ch.entry_shape == SHAPE_SPHERE);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      id_r[0]   <= in_ch.entry_id;
      last_r[0] <= in_ch.last_entry;
      mode_r[0] <= mode_nxt;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        id_r[k]   <= id_r[k-1];
        last_r[k] <= last_r[k-1];
        mode_r[k] <= mode_r[k-1];
      end
    end
  end

  // stage 1: interval bounds of both shapes and the radius to test against
  logic signed [C-1:0] ec [AXES];
  logic        [C-2:0] es [AXES];
  logic signed [C:0]   s1_qlo_nxt [AXES];
  logic signed [C:0]   s1_qhi_nxt [AXES];
  logic signed [C:0]   s1_elo_nxt [AXES];
  logic signed [C:0]   s1_ehi_nxt [AXES];
  logic        [C-1:0] s1_rad_nxt;
  logic signed [C:0]   s1_qlo_r [AXES];
  logic signed [C:0]   s1_qhi_r [AXES];
  logic signed [C:0]   s1_elo_r [AXES];
  logic signed [C:0]   s1_ehi_r [AXES];
  logic signed [C-1:0] s1_ec_r  [AXES];
  logic        [C-1:0] s1_rad_r;

  always_comb begin
    ec[0] = in_ch.entry_center_x;
    ec[1] = in_ch.entry_center_y;
    ec[2] = in_ch.entry_center_z;
    es[0] = in_ch.entry_size_x;
    es[1] = in_ch.entry_size_y;
    es[2] = in_ch.entry_size_z;
    for (int k = 0; k < AXES; k++) begin
      s1_qlo_nxt[k] = $signed({query_center[k][C-1], query_center[k]})
                    - $signed({2'b00, query_size[k]});
      s1_qhi_nxt[k] = $signed({query_center[k][C-1], query_center[k]})
                    + $signed({2'b00, query_size[k]});
      s1_elo_nxt[k] = $signed({ec[k][C-1], ec[k]}) - $signed({2'b00, es[k]});
      s1_ehi_nxt[k] = $signed({ec[k][C-1], ec[k]}) + $signed({2'b00, es[k]});
    end
    if (mode_nxt.q_sphere && mode_nxt.e_sphere) begin
      s1_rad_nxt = {1'b0, query_size[0]} + {1'b0, es[0]};
    end else if (mode_nxt.q_sphere) begin
      s1_rad_nxt = {1'b0, query_size[0]};
    end else begin
      s1_rad_nxt = {1'b0, es[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int k = 0; k < AXES; k++) begin
        s1_qlo_r[k] <= s1_qlo_nxt[k];
        s1_qhi_r[k] <= s1_qhi_nxt[k];
        s1_elo_r[k] <= s1_elo_nxt[k];
        s1_ehi_r[k] <= s1_ehi_nxt[k];
        s1_ec_r[k]  <= ec[k];
      end
      s1_rad_r <= s1_rad_nxt;
    end
  end

  // stage 2: distance from the sphere center to the box interval per axis;
  // two spheres use the query center as a point box
  logic signed [C:0]   blo [AXES];
  logic signed [C:0]   bhi [AXES];
  logic signed [C:0]   pt  [AXES];
  logic signed [C+1:0] dlo [AXES];
  logic signed [C+1:0] dhi [AXES];
  logic [AXES-1:0]     axis_ok;
  logic [C-1:0]        s2_d_nxt [AXES];
  logic [C-1:0]        s2_d_r   [AXES];
  logic [C-1:0]        s2_rad_r;
  logic                s2_bb_r;

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      if (!mode_r[0].q_sphere) begin
        blo[k] = s1_qlo_r[k];
        bhi[k] = s1_qhi_r[k];
        pt[k]  = $signed({s1_ec_r[k][C-1], s1_ec_r[k]});
      end else if (!mode_r[0].e_sphere) begin
        blo[k] = s1_elo_r[k];
        bhi[k] = s1_ehi_r[k];
        pt[k]  = $signed({query_center[k][C-1], query_center[k]});
      end else begin
        blo[k] = $signed({query_center[k][C-1], query_center[k]});
        bhi[k] = $signed({query_center[k][C-1], query_center[k]});
        pt[k]  = $signed({s1_ec_r[k][C-1], s1_ec_r[k]});
      end
      dlo[k] = $signed({blo[k][C], blo[k]}) - $signed({pt[k][C], pt[k]});
      dhi[k] = $signed({pt[k][C], pt[k]}) - $signed({bhi[k][C], bhi[k]});
      if (pt[k] < blo[k]) begin
        s2_d_nxt[k] = dlo[k][C-1:0];
      end else if (pt[k] > bhi[k]) begin
        s2_d_nxt[k] = dhi[k][C-1:0];
      end else begin
        s2_d_nxt[k] = '0;
      end
      axis_ok[k] = !(s1_qlo_r[k] > s1_ehi_r[k]) && !(s1_qhi_r[k] < s1_elo_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int k = 0; k < AXES; k++) begin
        s2_d_r[k] <= s2_d_nxt[k];
      end
      s2_rad_r <= s1_rad_r;
      s2_bb_r  <= &axis_ok;
    end
  end

  // stage 3: squares
  logic [SQ_BITS-1:0] s3_sq_r [AXES];
  logic [SQ_BITS-1:0] s3_rr_r;
  logic               s3_bb_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int k = 0; k < AXES; k++) begin
        s3_sq_r[k] <= s2_d_r[k] * s2_d_r[k];
      end
      s3_rr_r <= s2_rad_r * s2_rad_r;
      s3_bb_r <= s2_bb_r;
    end
  end

  // stages 4 and 5: sum of squares at full width
  logic [SQ_BITS:0]   s4_s01_r;
  logic [SQ_BITS-1:0] s4_sq2_r;
  logic [SQ_BITS-1:0] s4_rr_r;
  logic               s4_bb_r;
  logic [SQ_BITS+1:0] s5_sum_r;
  logic [SQ_BITS-1:0] s5_rr_r;
  logic               s5_bb_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_s01_r <= {1'b0, s3_sq_r[0]} + {1'b0, s3_sq_r[1]};
      s4_sq2_r <= s3_sq_r[2];
      s4_rr_r  <= s3_rr_r;
      s4_bb_r  <= s3_bb_r;
    end
    if (adv[4]) begin
      s5_sum_r <= {1'b0, s4_s01_r} + {2'b00, s4_sq2_r};
      s5_rr_r  <= s4_rr_r;
      s5_bb_r  <= s4_bb_r;
    end
  end

  // stage 6: final compare, doubles as the output register
  logic s6_hit_nxt;
  logic s6_hit_r;

  always_comb begin
    if (!mode_r[4].q_sphere && !mode_r[4].e_sphere) begin
      s6_hit_nxt = s5_bb_r;
    end else begin
      s6_hit_nxt = (s5_sum_r <= {2'b00, s5_rr_r});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) s6_hit_r <= s6_hit_nxt;
  end

  assign out_ch.valid       = vld_r[NUM_STAGES-1];
  assign out_ch.overlaps    = s6_hit_r;
  assign out_ch.result_id   = id_r[NUM_STAGES-1];
  assign out_ch.last_result = last_r[NUM_STAGES-1];

endmodule

/* design/box_sphere_overlap_query_top.sv */
// top level of the box / sphere overlap query: query registers and test pipeline
//
//   channel  dir  payload                                         transaction
//   cfg_ch   in   index, data                                     valid & ready
//   in_ch    in   entry shape, center xyz, size xyz, id, last     valid & ready
//   out_ch   out  overlaps, result_id, last_result                valid & ready
//
// one entry per cycle unless out_ch stalls, through a six-stage pipeline
// whose slowest steps are the 32x32 squarers and the wide sum of squares
// cfg_ch is always ready; the query registers reset to zero (box at origin)
// a stalled out_ch holds its result; each stage keeps filling while empty
// stages ahead of it remain, so no transaction is dropped or repeated
module box_sphere_overlap_query_top import bsoq_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int ID_BITS    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  bsoq_cfg_if.sink      cfg_ch,
  bsoq_entry_if.sink    in_ch,
  bsoq_result_if.source out_ch
);

  logic                         query_shape_r;
  logic signed [COORD_BITS-1:0] query_center_r [AXES];
  logic        [COORD_BITS-2:0] query_size_r   [AXES];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_shape_r <= SHAPE_BOX;
      for (int k = 0; k < AXES; k++) begin
        query_center_r[k] <= '0;
        query_size_r[k]   <= '0;
      end
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_QUERY_SHAPE:    query_shape_r     <= cfg_ch.data[0];
        REG_QUERY_CENTER_X: query_center_r[0] <= cfg_ch.data;
        REG_QUERY_CENTER_Y: query_center_r[1] <= cfg_ch.data;
        REG_QUERY_CENTER_Z: query_center_r[2] <= cfg_ch.data;
        REG_QUERY_SIZE_X:   query_size_r[0]   <= cfg_ch.data[COORD_BITS-2:0];
        REG_QUERY_SIZE_Y:   query_size_r[1]   <= cfg_ch.data[COORD_BITS-2:0];
        REG_QUERY_SIZE_Z:   query_size_r[2]   <= cfg_ch.data[COORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  bsoq_pipe #(
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
  ) u_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_shape  (query_shape_r),
    .query_center (query_center_r),
    .query_size   (query_size_r),
    .in_ch        (in_ch),
    .out_ch       (out_ch)
  );

endmodule

/* bench/testbench.sv */
// self-checking testbench for the box / sphere overlap query block
module testbench;
  import bsoq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS    = 32;
  localparam int ID_BITS       = 16;
  localparam int PIPE_LATENCY  = 6;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ENTRIES = 150;

  // index with no register behind it
  localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

  localparam logic [COORD_BITS-1:0] ONE   = 32'h0001_0000;
  localparam logic [COORD_BITS-1:0] C_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_BITS-1:0] C_MIN = 32'h8000_0000;
  localparam logic [COORD_BITS-1:0] S_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic                         sphere;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic        [COORD_BITS-2:0] sx;
    logic        [COORD_BITS-2:0] sy;
    logic        [COORD_BITS-2:0] sz;
  } geom_t;

  typedef struct packed {
    logic               overlaps;
    logic [ID_BITS-1:0] id;
    logic               last;
  } verdict_t;

  logic clk;
  logic rst_n;

  bsoq_cfg_if    #(.COORD_BITS(COORD_BITS))                    cfg_ch ();
  bsoq_entry_if  #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) in_ch ();
  bsoq_result_if #(.ID_BITS(ID_BITS))                          out_ch ();

  box_sphere_overlap_query_top #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  geom_t    query;
  verdict_t expected_verdicts[$];
  int       mismatches;
  int       entries_sent;
  int       results_checked;
  int       hits_seen;
  int       settings_used;
  bit       no_idle;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic longint axis_center(geom_t g, int k);
    case (k)
      0:       return longint'($signed(g.cx));
      1:       return longint'($signed(g.cy));
      default: return longint'($signed(g.cz));
    endcase
  endfunction

  function automatic longint axis_size(geom_t g, int k);
    case (k)
      0:       return longint'(g.sx);
      1:       return longint'(g.sy);
      default: return longint'(g.sz);
    endcase
  endfunction

  function automatic logic [127:0] square_of(longint v);
    logic [127:0] m;
    m = 128'((v < 0) ? -v : v);
    return m * m;
  endfunction

  function automatic logic boxes_meet(geom_t a, geom_t b);
    for (int k = 0; k < AXES; k++) begin
      if (axis_center(a, k) - axis_size(a, k) > axis_center(b, k) + axis_size(b, k))
        return 1'b0;
      if (axis_center(a, k) + axis_size(a, k) < axis_center(b, k) - axis_size(b, k))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic spheres_meet(geom_t a, geom_t b);
    logic [127:0] sq_sum;
    sq_sum = '0;
    for (int k = 0; k < AXES; k++)
      sq_sum += square_of(axis_center(a, k) - axis_center(b, k));
    return sq_sum <= square_of(axis_size(a, 0) + axis_size(b, 0));
  endfunction

  // closest point of the box to the sphere center, then distance against radius
  function automatic logic box_meets_sphere(geom_t box, geom_t sph);
    logic [127:0] sq_sum;
    longint       lo;
    longint       hi;
    longint       p;
    sq_sum = '0;
    for (int k = 0; k < AXES; k++) begin
      lo = axis_center(box, k) - axis_size(box, k);
      hi = axis_center(box, k) + axis_size(box, k);
      p  = axis_center(sph, k);
      if (p < lo) p = lo;
      if (p > hi) p = hi;
      sq_sum += square_of(axis_center(sph, k) - p);
    end
    return sq_sum <= square_of(axis_size(sph, 0));
  endfunction

  function automatic logic overlap_of(geom_t q, geom_t e);
    if (q.sphere == SHAPE_BOX && e.sphere == SHAPE_BOX) return boxes_meet(q, e);
    if (q.sphere == SHAPE_SPHERE && e.sphere == SHAPE_SPHERE) return spheres_meet(q, e);
    if (q.sphere == SHAPE_BOX) return box_meets_sphere(q, e);
    return box_meets_sphere(e, q);
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic geom_t mk_geom(logic sphere, logic [COORD_BITS-1:0] cx,
                                    logic [COORD_BITS-1:0] cy, logic [COORD_BITS-1:0] cz,
                                    logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                                    logic [COORD_BITS-1:0] sz);
    geom_t g;
    g.sphere = sphere;
    g.cx = cx;
    g.cy = cy;
    g.cz = cz;
    g.sx = sx[COORD_BITS-2:0];
    g.sy = sy[COORD_BITS-2:0];
    g.sz = sz[COORD_BITS-2:0];
    return g;
  endfunction

  // mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // signed value within about +/- 2^k
  function automatic logic [COORD_BITS-1:0] rand_scaled(int k);
    logic signed [COORD_BITS-1:0] r;
    r = $urandom;
    return r >>> (31 - k);
  endfunction

  function automatic logic [COORD_BITS-2:0] rand_size(int k);
    logic [31:0] r;
    r = $urandom;
    return 31'(r >> (32 - k));
  endfunction

  function automatic geom_t random_query(int phase);
    geom_t g;
    case (phase)
      0: g = mk_geom(SHAPE_BOX, C_MAX, C_MAX, C_MAX, S_MAX, S_MAX, S_MAX);
      1: g = mk_geom(SHAPE_SPHERE, C_MIN, C_MIN, C_MIN, 0, 0, 0);
      2: g = mk_geom(SHAPE_SPHERE, 0, 0, 0, S_MAX, S_MAX, S_MAX);
      3: g = mk_geom(SHAPE_BOX, C_MIN, C_MAX, 0, 0, 0, 0);
      default: begin
        g.sphere = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) begin
          g.cx = $urandom;
          g.cy = $urandom;
          g.cz = $urandom;
        end else begin
          g.cx = rand_scaled($urandom_range(0, 31));
          g.cy = rand_scaled($urandom_range(0, 31));
          g.cz = rand_scaled($urandom_range(0, 31));
        end
        g.sx = rand_size($urandom_range(0, 31));
        g.sy = rand_size($urandom_range(0, 31));
        g.sz = rand_size($urandom_range(0, 31));
      end
    endcase
    return g;
  endfunction

  // most entries land near the query, half of those at a scale close to its size; the rest anywhere
  function automatic geom_t random_entry(geom_t q);
    geom_t g;
    int    k;
    g.sphere = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      g.cx = $urandom;
      g.cy = $urandom;
      g.cz = $urandom;
      g.sx = 31'($urandom);
      g.sy = 31'($urandom);
      g.sz = 31'($urandom);
    end else begin
      if ($urandom_range(0, 1) == 0)
        k = $urandom_range(0, 31);
      else
        k = $clog2(longint'(q.sx) + 1) - 2 + int'($urandom_range(0, 4));
      if (k < 0) k = 0;
      if (k > 31) k = 31;
      g.cx = q.cx + rand_scaled(k);
      g.cy = q.cy + rand_scaled(k);
      g.cz = q.cz + rand_scaled(k);
      g.sx = rand_size($urandom_range(0, k));
      g.sy = rand_size($urandom_range(0, k));
      g.sz = rand_size($urandom_range(0, k));
    end
    return g;
  endfunction

  // ---------------------------------------------------------------- channel drivers

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_QUERY_SHAPE:    query.sphere = data[0];
      REG_QUERY_CENTER_X: query.cx = data;
      REG_QUERY_CENTER_Y: query.cy = data;
      REG_QUERY_CENTER_Z: query.cz = data;
      REG_QUERY_SIZE_X:   query.sx = data[COORD_BITS-2:0];
      REG_QUERY_SIZE_Y:   query.sy = data[COORD_BITS-2:0];
      REG_QUERY_SIZE_Z:   query.sz = data[COORD_BITS-2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // random junk above each register's width must be dropped
  task automatic program_query(geom_t g);
    cfg_write(REG_QUERY_SHAPE, {31'($urandom), g.sphere});
    cfg_write(REG_QUERY_CENTER_X, g.cx);
    cfg_write(REG_QUERY_CENTER_Y, g.cy);
    cfg_write(REG_QUERY_CENTER_Z, g.cz);
    cfg_write(REG_QUERY_SIZE_X, {1'($urandom), g.sx});
    cfg_write(REG_QUERY_SIZE_Y, {1'($urandom), g.sy});
    cfg_write(REG_QUERY_SIZE_Z, {1'($urandom), g.sz});
    settings_used++;
  endtask

  task automatic send_entry(geom_t g, logic [ID_BITS-1:0] id, logic last);
    verdict_t v;
    int       gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.entry_shape    <= g.sphere;
    in_ch.entry_center_x <= g.cx;
    in_ch.entry_center_y <= g.cy;
    in_ch.entry_center_z <= g.cz;
    in_ch.entry_size_x   <= g.sx;
    in_ch.entry_size_y   <= g.sy;
    in_ch.entry_size_z   <= g.sz;
    in_ch.entry_id       <= id;
    in_ch.last_entry     <= last;
    do @(posedge clk); while (!in_ch.ready);
    v.overlaps = overlap_of(query, g);
    v.id       = id;
    v.last     = last;
    expected_verdicts.insert(expected_verdicts.size(), v);
    entries_sent++;
  endtask

  // stop sending and let every pending result come out
  task automatic wait_for_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : result_sink
    int run;
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      if (no_idle)
        run = 1;
      else if ($urandom_range(0, 9) == 0)
        run = $urandom_range(50, 150);
      else
        run = $urandom_range(1, 8);
      @(negedge clk) out_ch.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      stall = no_idle ? 0 : pick_gap();
      if (stall > 0) begin
        @(negedge clk) out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result with no entry pending: id %0h", out_ch.result_id);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        results_checked++;
        if (out_ch.overlaps === 1'b1) hits_seen++;
        if (out_ch.overlaps !== want.overlaps) begin
          $error("overlaps: expected %0b, got %0b (id %0h)", want.overlaps, out_ch.overlaps,
                 want.id);
          mismatches++;
        end
        if (out_ch.result_id !== want.id) begin
          $error("result_id: expected %0h, got %0h", want.id, out_ch.result_id);
          mismatches++;
        end
        if (out_ch.last_result !== want.last) begin
          $error("last_result: expected %0b, got %0b (id %0h)", want.last,
                 out_ch.last_result, want.id);
          mismatches++;
        end
      end
    end
  end

  // cycles in a row with no transaction on any channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // reset query is a box of zero size at the origin
  task automatic test_point_queries();
    send_entry(mk_geom(SHAPE_BOX, 0, 0, 0, 0, 0, 0), 16'h0000, 1'b0);
    send_entry(mk_geom(SHAPE_SPHERE, 0, 0, 0, 0, 0, 0), 16'h0001, 1'b0);
    send_entry(mk_geom(SHAPE_BOX, 1, 0, 0, 0, 0, 0), 16'h8000, 1'b0);
    send_entry(mk_geom(SHAPE_SPHERE, 0, 0, 1, 0, 0, 0), 16'hFFFF, 1'b1);
  endtask

  task automatic test_box_pairs();
    wait_for_drain();
    program_query(mk_geom(SHAPE_BOX, 0, 0, 0, ONE, ONE, ONE));
    send_entry(mk_geom(SHAPE_BOX, 2 * ONE, 0, 0, ONE, ONE, ONE), 16'h0010, 1'b0);
    send_entry(mk_geom(SHAPE_BOX, 2 * ONE + 1, 0, 0, ONE, ONE, ONE), 16'h0011, 1'b0);
    send_entry(mk_geom(SHAPE_BOX, 0, 0, -2 * ONE, ONE, ONE, ONE), 16'h0012, 1'b0);
    send_entry(mk_geom(SHAPE_BOX, C_MIN, C_MIN, C_MIN, S_MAX, S_MAX, S_MAX), 16'h0013, 1'b0);
    send_entry(mk_geom(SHAPE_BOX, C_MAX, C_MAX, C_MAX, 0, 0, 0), 16'h0014, 1'b1);
  endtask

  task automatic test_sphere_pairs();
    wait_for_drain();
    // y and z sizes of a sphere carry no meaning
    program_query(mk_geom(SHAPE_SPHERE, 0, 0, 0, 2 * ONE, S_MAX, S_MAX));
    send_entry(mk_geom(SHAPE_SPHERE, 3 * ONE, 4 * ONE, 0, 3 * ONE, 0, 0), 16'h0020, 1'b0);
    send_entry(mk_geom(SHAPE_SPHERE, 3 * ONE, 4 * ONE, 0, 3 * ONE - 1, 0, 0), 16'h0021, 1'b0);
    send_entry(mk_geom(SHAPE_SPHERE, 0, 0, 0, 0, S_MAX, S_MAX), 16'h0022, 1'b0);
    send_entry(mk_geom(SHAPE_SPHERE, C_MIN, C_MIN, C_MIN, S_MAX, 0, 0), 16'h0023, 1'b1);
    wait_for_drain();
    program_query(mk_geom(SHAPE_SPHERE, C_MAX, C_MAX, C_MAX, S_MAX, 0, 0));
    send_entry(mk_geom(SHAPE_SPHERE, C_MIN, C_MIN, C_MIN, S_MAX, 0, 0), 16'h0024, 1'b0);
    send_entry(mk_geom(SHAPE_SPHERE, C_MAX, C_MAX, C_MAX, 0, 0, 0), 16'h0025, 1'b0);
    send_entry(mk_geom(SHAPE_BOX, C_MIN, C_MIN, C_MIN, S_MAX, S_MAX, S_MAX), 16'h0026, 1'b1);
  endtask

  // sphere off a box corner, a 3-4-5 triangle in raw units
  task automatic test_mixed_pairs();
    wait_for_drain();
    program_query(mk_geom(SHAPE_BOX, 0, 0, 0, ONE, ONE, ONE));
    send_entry(mk_geom(SHAPE_SPHERE, ONE + 3, ONE + 4, 0, 5, 0, 0), 16'h0030, 1'b0);
    send_entry(mk_geom(SHAPE_SPHERE, ONE + 3, ONE + 4, 0, 4, 0, 0), 16'h0031, 1'b0);
    send_entry(mk_geom(SHAPE_SPHERE, 0, 0, 0, 0, 0, 0), 16'h0032, 1'b1);
    wait_for_drain();
    program_query(mk_geom(SHAPE_SPHERE, ONE + 3, ONE + 4, 0, 5, 0, 0));
    send_entry(mk_geom(SHAPE_BOX, 0, 0, 0, ONE, ONE, ONE), 16'h0033, 1'b0);
    send_entry(mk_geom(SHAPE_BOX, 0, 0, 0, ONE - 1, ONE, ONE), 16'h0034, 1'b1);
  endtask

  task automatic test_register_writes();
    wait_for_drain();
    program_query(mk_geom(SHAPE_BOX, 0, 0, 0, 0, 0, 0));
    cfg_write(REG_QUERY_SHAPE, 32'hFFFF_FFFE);
    cfg_write(REG_QUERY_SIZE_X, 32'hFFFF_FFFF);
    cfg_write(REG_UNMAPPED, 32'h0000_0001);
    // a box query misses this point, a sphere query would hit it
    send_entry(mk_geom(SHAPE_BOX, ONE, 0, 1, 0, 0, 0), 16'h0040, 1'b0);
    send_entry(mk_geom(SHAPE_BOX, C_MIN, 0, 0, 0, 0, 0), 16'h0041, 1'b0);
    send_entry(mk_geom(SHAPE_BOX, C_MIN + 1, 0, 0, 0, 0, 0), 16'h0042, 1'b1);
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_drain();
      program_query(random_query(phase));
      no_idle = (phase % 4 == 2);
      for (int n = 0; n < PHASE_ENTRIES; n++) begin
        if (phase == 5 && n == PHASE_ENTRIES / 2) wait_for_drain();
        send_entry(random_entry(query), 16'($urandom), $urandom_range(0, 15) == 0);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n                = 1'b0;
    query                = '0;
    mismatches           = 0;
    entries_sent         = 0;
    results_checked      = 0;
    hits_seen            = 0;
    settings_used        = 1;
    no_idle              = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_QUERY_SHAPE;
    cfg_ch.data          = '0;
    in_ch.valid          = 1'b0;
    in_ch.entry_shape    = SHAPE_BOX;
    in_ch.entry_center_x = '0;
    in_ch.entry_center_y = '0;
    in_ch.entry_center_z = '0;
    in_ch.entry_size_x   = '0;
    in_ch.entry_size_y   = '0;
    in_ch.entry_size_z   = '0;
    in_ch.entry_id       = '0;
    in_ch.last_entry     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_point_queries();
    test_box_pairs();
    test_sphere_pairs();
    test_mixed_pairs();
    test_register_writes();
    test_random_stream();
    wait_for_drain();

    $display("%0d entries sent over %0d query settings, all four shape pairings", entries_sent,
             settings_used);
    $display("%0d results checked, %0d of them overlapping", results_checked, hits_seen);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
design/bsoq_pkg.sv
design/bsoq_if.sv
design/bsoq_pipe.sv
design/box_sphere_overlap_query_top.sv
bench/testbench.sv
